[hw/rtl/lcss_pkg.sv]
// Shared types and constants for the cue stack sequencer.
// Used by the control, datapath and divider modules and by the top level.
package lcss_pkg;

  // Q16 fixed-point anchors
  localparam logic [16:0] Q_ONE       = 17'h10000;
  localparam logic [16:0] Q_SKIP      = 17'd65470;
  localparam logic [19:0] INSTANT_MS  = 20'd20;
  localparam logic [19:0] DEAD_OFFSET = 20'd32768;
  // ceil(2^23 / 9): exact divide by nine for any 20-bit dead-zone value
  localparam logic [19:0] DEAD_RECIP  = 20'd932068;
  localparam logic [15:0] MASTER_RST  = 16'hFFFF;

  // Divider geometry
  localparam int DIV_NW = 32;
  localparam int DIV_DW = 20;
  localparam int DIV_CW = 6;

  // Request modes
  localparam logic [2:0] MODE_TICK   = 3'd0;
  localparam logic [2:0] MODE_GO     = 3'd1;
  localparam logic [2:0] MODE_MANUAL = 3'd2;
  localparam logic [2:0] MODE_CLEAR  = 3'd3;
  localparam logic [2:0] MODE_TOGGLE = 3'd4;
  localparam logic [2:0] MODE_WRITE  = 3'd5;

  // Scene events
  localparam logic [1:0] EV_NONE    = 2'd0;
  localparam logic [1:0] EV_XFADE   = 2'd1;
  localparam logic [1:0] EV_FADEEND = 2'd2;
  localparam logic [1:0] EV_CLEARED = 2'd3;

  // Register index (address bit 2)
  localparam logic REG_CUE_COUNT = 1'b0;
  localparam logic REG_MASTER    = 1'b1;

  typedef struct packed {
    logic [2:0]  mode;
    logic [15:0] elapsed_ms;
    logic [15:0] fader_level;
    logic [5:0]  cue_index;
    logic [19:0] fade_time_ms;
    logic [19:0] hold_time_ms;
    logic        follow;
  } item_t;

  typedef struct packed {
    logic [5:0]  active_cue;
    logic        active_valid;
    logic [5:0]  last_cue;
    logic        last_valid;
    logic [5:0]  pending_cue;
    logic        running;
    logic [16:0] fade_position;
    logic [16:0] hold_position;
    logic [15:0] active_weight;
    logic [15:0] last_weight;
    logic [1:0]  scene_event;
  } result_t;

  typedef struct packed {
    logic in_load;
    logic tab_read;
    logic div_start;
    logic apply;
    logic mul_act;
    logic mul_last;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic [2:0] mode;
    logic       div_done;
  } status_t;

endpackage

[hw/rtl/lighting_cue_stack_sequencer.sv]
// Cue stack sequencer: takes one request at a time and returns one result for it.
// A tick request is routed through the 32-step restoring divider that forms elapsed
// over phase time; go, manual fader, clear, toggle, write and unused modes bypass it
// (the fader dead-zone value is divided by nine with a reciprocal multiply). A new
// result waits in the emit state while a stalled result is still held. The
// next request is taken as soon as the previous one sits in the result register.
// Cue table entries read before being written give undefined times; there is no
// clearing pass after reset.
module lighting_cue_stack_sequencer #(
  parameter int MAX_CUES = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  lcss_pkg::item_t   item,
  output logic              result_valid,
  input  logic              result_stall,
  output lcss_pkg::result_t result,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  import lcss_pkg::*;

  cmd_t    cmd;
  status_t status;

  assign pready = 1'b1;

  lcss_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .status       (status),
    .cmd          (cmd)
  );

  lcss_dp #(.MAX_CUES(MAX_CUES)) u_dp (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .status  (status),
    .item    (item),
    .result  (result),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata)
  );

endmodule

[hw/rtl/lcss_div.sv]
// Restoring divider, one quotient bit per cycle.
// Depends on lcss_pkg for its widths.
module lcss_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [lcss_pkg::DIV_NW-1:0] dividend,
  input  logic [lcss_pkg::DIV_DW-1:0] divisor,
  output logic                        busy,
  output logic                        done,
  output logic [lcss_pkg::DIV_NW-1:0] quotient
);
  import lcss_pkg::*;

  logic [DIV_DW-1:0] rem;
  logic [DIV_CW-1:0] cnt;
  logic [DIV_DW:0]   shifted;
  logic              fits;

  // Trial subtract of the next partial remainder
  always_comb begin
    shifted = {rem, quotient[DIV_NW-1]};
    fits    = shifted >= {1'b0, divisor};
  end

  // Shift one bit in per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == DIV_CW'(1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= DIV_CW'(DIV_NW);
      end else if (busy) begin
        cnt <= cnt - DIV_CW'(1);
        if (cnt == DIV_CW'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      quotient <= dividend;
    end else if (busy) begin
      rem      <= fits ? DIV_DW'(shifted - {1'b0, divisor}) : shifted[DIV_DW-1:0];
      quotient <= {quotient[DIV_NW-2:0], fits};
    end
  end

endmodule

[hw/rtl/lcss_ctrl.sv]
// Sequencing state machine for the cue stack sequencer.
// Depends on lcss_pkg for the command and status structs.
module lcss_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  output logic              result_valid,
  input  logic              result_stall,
  input  lcss_pkg::status_t status,
  output lcss_pkg::cmd_t    cmd
);
  import lcss_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_READ, S_START, S_DIVW, S_APPLY, S_MULA, S_MULL, S_EMIT
  } state_t;

  state_t state, state_next;
  logic   needs_div;

  assign needs_div  = (status.mode == MODE_TICK);
  assign item_stall = (state != S_IDLE);

  // Decode commands from the current state
  always_comb begin
    cmd           = '0;
    cmd.in_load   = (state == S_IDLE) && item_valid;
    cmd.tab_read  = (state == S_READ);
    cmd.div_start = (state == S_START);
    cmd.apply     = (state == S_APPLY);
    cmd.mul_act   = (state == S_MULA);
    cmd.mul_last  = (state == S_MULL);
    cmd.out_load  = (state == S_EMIT) && (!result_valid || !result_stall);
  end

  // Step through one request
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (item_valid) state_next = S_READ;
      S_READ:  state_next = needs_div ? S_START : S_APPLY;
      S_START: state_next = S_DIVW;
      S_DIVW:  if (status.div_done) state_next = S_APPLY;
      S_APPLY: state_next = S_MULA;
      S_MULA:  state_next = S_MULL;
      S_MULL:  state_next = S_EMIT;
      S_EMIT:  if (cmd.out_load) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Hold state and the result valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

`ifndef ASSERT_OFF
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!result_valid || !result_stall))
    else $error("result loaded over a stalled result");
  a_apply_once: assert property (@(posedge clk) disable iff (rst)
    cmd.apply |=> !cmd.apply)
    else $error("request applied twice");
  a_emit_leaves: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |=> (state == S_IDLE))
    else $error("no return to idle after emit");
`endif

endmodule

[hw/rtl/lcss_dp.sv]
// Datapath: cue table, playback state, divider, weight multiplier, registers.
// Depends on lcss_pkg and lcss_div.
module lcss_dp #(
  parameter int MAX_CUES = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  lcss_pkg::cmd_t    cmd,
  output lcss_pkg::status_t status,
  input  lcss_pkg::item_t   item,
  output lcss_pkg::result_t result,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata
);
  import lcss_pkg::*;

  localparam int IW = (MAX_CUES > 1) ? $clog2(MAX_CUES) : 1;
  localparam int CW = IW + 1;
  localparam int NW = (CW > 7) ? CW : 7;

  typedef struct packed {
    logic [IW-1:0] act;
    logic          act_ok;
    logic [IW-1:0] prv;
    logic          prv_ok;
    logic [IW-1:0] nxt;
    logic          nxt_ok;
  } ptr_t;

  typedef struct packed {
    logic [19:0] fade;
    logic [19:0] hold;
    logic        follow;
  } entry_t;

  // Pick the pending cue after the active one, wrapping to the first
  function automatic ptr_t choose(ptr_t p, logic [NW-1:0] n);
    ptr_t          r;
    logic [NW-1:0] idx;
    r   = p;
    idx = NW'(p.act);
    if (!p.act_ok) begin
      if (n != '0) begin
        r.nxt    = '0;
        r.nxt_ok = 1'b1;
      end
    end else if (n != '0) begin
      if (idx >= n) begin
        r.act = '0;
        idx   = '0;
      end
      r.nxt    = ((idx + NW'(1)) >= n) ? '0 : IW'(idx + NW'(1));
      r.nxt_ok = 1'b1;
    end
    return r;
  endfunction

  function automatic ptr_t advance(ptr_t p, logic [NW-1:0] n);
    ptr_t r;
    r        = p;
    r.prv    = p.act;
    r.prv_ok = p.act_ok;
    if (!r.nxt_ok) r = choose(r, n);
    r.act    = r.nxt;
    r.act_ok = r.nxt_ok;
    return choose(r, n);
  endfunction

  function automatic logic [16:0] step_pos(logic [16:0] pos, logic [31:0] q,
                                           logic [19:0] t);
    logic [32:0] s;
    s = {16'b0, pos} + {1'b0, q};
    if (t <= INSTANT_MS) return Q_ONE;
    return (s >= 33'(Q_ONE)) ? Q_ONE : s[16:0];
  endfunction

  entry_t        cue_mem [MAX_CUES];
  entry_t        tab;
  item_t         req;
  ptr_t          ptr, ptr_n;
  logic          run, run_n, up, up_n;
  logic [16:0]   fade, fade_n, hold, hold_n, val;
  logic [1:0]    ev, ev_n;
  logic [6:0]    cue_count;
  logic [15:0]   master;
  logic [NW-1:0] used, cnt_ext;
  logic          wr_ok;
  logic [19:0]   v10, dead;
  logic [39:0]   dz_prod;
  logic [31:0]   dividend, quotient;
  logic [19:0]   divisor;
  logic          div_busy, div_done;
  logic [32:0]   prod;
  logic [15:0]   aw;

  assign status.mode     = req.mode;
  assign status.div_done = div_done;

  assign cnt_ext = NW'(cue_count);
  assign used    = (cnt_ext > NW'(MAX_CUES)) ? NW'(MAX_CUES) : cnt_ext;
  assign wr_ok   = NW'(req.cue_index) < NW'(MAX_CUES);

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cue_count <= '0;
      master    <= MASTER_RST;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        REG_CUE_COUNT: cue_count <= pwdata[6:0];
        REG_MASTER:    master    <= pwdata[15:0];
        default:       ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_CUE_COUNT: prdata = {25'b0, cue_count};
      REG_MASTER:    prdata = {16'b0, master};
      default:       prdata = '0;
    endcase
  end

  // Latch the accepted request
  always_ff @(posedge clk) begin
    if (cmd.in_load) req <= item;
  end

  // Cue table: write on apply of an in-range write request, registered read of the active cue
  always_ff @(posedge clk) begin
    if (cmd.apply && (req.mode == MODE_WRITE) && wr_ok) begin
      cue_mem[IW'(req.cue_index)] <= {req.fade_time_ms, req.hold_time_ms, req.follow};
    end
    if (cmd.tab_read) tab <= cue_mem[ptr.act];
  end

  // Dead-zone fader value over nine by reciprocal multiply
  always_comb begin
    v10     = ({4'b0, req.fader_level} << 3) + ({4'b0, req.fader_level} << 1);
    dead    = (v10 > DEAD_OFFSET) ? (v10 - DEAD_OFFSET) : '0;
    dz_prod = 40'(dead) * 40'(DEAD_RECIP);
  end

  // Hold the fader value, capped at one
  always_ff @(posedge clk) begin
    if (cmd.tab_read) val <= (dz_prod[39:23] > Q_ONE) ? Q_ONE : dz_prod[39:23];
  end

  // Divider operands: elapsed over the current phase time
  assign dividend = {req.elapsed_ms, 16'b0};
  assign divisor  = (fade < Q_ONE) ? tab.fade : tab.hold;

  lcss_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (dividend),
    .divisor  (divisor),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (quotient)
  );

  // Next playback state for the request
  always_comb begin
    ptr_n  = ptr;
    run_n  = run;
    up_n   = up;
    fade_n = fade;
    hold_n = hold;
    ev_n   = EV_NONE;
    unique case (req.mode)
      MODE_TICK: begin
        if (run) begin
          if (!ptr.act_ok) begin
            run_n = 1'b0;
          end else if (fade < Q_ONE) begin
            fade_n = step_pos(fade, quotient, tab.fade);
            if (fade_n < Q_ONE) begin
              ev_n = EV_XFADE;
            end else begin
              if (!tab.follow) run_n = 1'b0;
              ev_n = EV_FADEEND;
            end
          end else if (hold < Q_ONE) begin
            if (!tab.follow) begin
              hold_n = Q_ONE;
            end else begin
              hold_n = step_pos(hold, quotient, tab.hold);
              if (hold_n >= Q_ONE) begin
                ptr_n  = advance(ptr, used);
                fade_n = '0;
                hold_n = '0;
                run_n  = 1'b1;
              end
            end
          end else begin
            run_n = 1'b0;
          end
        end
      end
      MODE_GO: begin
        if ((fade < Q_ONE) && ptr.act_ok) begin
          fade_n = Q_SKIP;
        end else if ((hold < Q_ONE) && ptr.act_ok && tab.follow) begin
          hold_n = Q_SKIP;
        end else begin
          ptr_n  = advance(ptr, used);
          fade_n = '0;
          hold_n = '0;
        end
        run_n = 1'b1;
      end
      MODE_MANUAL: begin
        if (!ptr.act_ok) begin
          if (!ptr_n.nxt_ok) ptr_n = choose(ptr_n, used);
          ptr_n.act    = ptr_n.nxt;
          ptr_n.act_ok = ptr_n.nxt_ok;
          fade_n       = '0;
          hold_n       = '0;
          ptr_n        = choose(ptr_n, used);
        end
        if (ptr_n.act_ok) begin
          if (fade_n >= Q_ONE) ptr_n = advance(ptr_n, used);
          fade_n = up ? val : (Q_ONE - val);
          if (fade_n < Q_ONE) begin
            ev_n = EV_XFADE;
          end else begin
            up_n = !up;
            ev_n = EV_FADEEND;
          end
        end
      end
      MODE_CLEAR: begin
        run_n        = 1'b0;
        ptr_n.prv_ok = 1'b0;
        ptr_n.nxt    = ptr.act;
        ptr_n.nxt_ok = ptr.act_ok;
        ptr_n.act_ok = 1'b0;
        fade_n       = '0;
        hold_n       = '0;
        ev_n         = EV_CLEARED;
      end
      MODE_TOGGLE: run_n = !run;
      default: ;
    endcase
  end

  // Commit the playback state
  always_ff @(posedge clk) begin
    if (rst) begin
      ptr.act_ok <= 1'b0;
      ptr.prv_ok <= 1'b0;
      ptr.nxt_ok <= 1'b0;
      ptr.act    <= '0;
      ptr.prv    <= '0;
      ptr.nxt    <= '0;
      run        <= 1'b0;
      up         <= 1'b1;
      fade       <= '0;
      hold       <= '0;
    end else if (cmd.apply) begin
      ptr  <= ptr_n;
      run  <= run_n;
      up   <= up_n;
      fade <= fade_n;
      hold <= hold_n;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.apply) ev <= ev_n;
  end

  // Weights: active then last, one multiply per cycle
  always_ff @(posedge clk) begin
    if (cmd.mul_act) begin
      prod <= 33'(fade) * 33'(master);
    end else if (cmd.mul_last) begin
      aw   <= ptr.act_ok ? prod[31:16] : '0;
      prod <= 33'(Q_ONE - fade) * 33'(master);
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      result.active_cue    <= ptr.act_ok ? 6'(ptr.act) : '0;
      result.active_valid  <= ptr.act_ok;
      result.last_cue      <= ptr.prv_ok ? 6'(ptr.prv) : '0;
      result.last_valid    <= ptr.prv_ok;
      result.pending_cue   <= ptr.nxt_ok ? 6'(ptr.nxt) : '0;
      result.running       <= run;
      result.fade_position <= fade;
      result.hold_position <= hold;
      result.active_weight <= aw;
      result.last_weight   <= ptr.prv_ok ? prod[31:16] : '0;
      result.scene_event   <= ev;
    end
  end

`ifndef ASSERT_OFF
  a_fade_cap: assert property (@(posedge clk) disable iff (rst) fade <= Q_ONE)
    else $error("fade position above one");
  a_hold_cap: assert property (@(posedge clk) disable iff (rst) hold <= Q_ONE)
    else $error("hold position above one");
  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    (cmd.apply || cmd.div_start) |-> !div_busy)
    else $error("divider busy at start or apply");
`endif

endmodule
